@@ rtl/core/brts_pkg.sv @@
package brts_pkg;

    // Fixed widths of the fields and the table depth
    localparam int ADDR_W    = 14;
    localparam int TDEPTH    = 16384;
    localparam int ENTRY_W   = 17;
    localparam int TAU_W     = 32;
    localparam int XI_W      = 17;
    localparam int MIN_W     = 24;
    localparam int SCALE_W   = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 24;

    // Q1.16 one
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Item kinds carried in tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_TAU_MIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_SCALE = 1'b1;

endpackage

@@ rtl/core/bilinear_radius_table_sampler_unit.sv @@
// Bilinear radius table sampler. A write transfer (tuser 1) stores one table
// entry and gives no result; a sample transfer (tuser 0) maps tau through an
// approximate log2 to a row position and xi to a column position, reads the
// four neighboring entries and interpolates them, giving one radius result.
// The block takes one transfer every cycle while s_tready is high. A sample
// result passes, when the output is not stalled, through stages A to I and
// then the output register before m_tvalid rises. A stalled output fills a skid
// register, and s_tready stays low while that register holds a result.
// The table is held in four copies of the RAM so that the four neighbors are
// read in the same cycle, and every table write goes to all four. A sample must
// only read entries written since reset. The user writes registers through
// the configuration port only while the block is idle; the block does not enforce this.
module bilinear_radius_table_sampler_unit #(
    parameter int TAU_ROWS = 128,
    parameter int XI_COLS  = 128
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [brts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [brts_pkg::CFG_W-1:0]           cfg_wr_data,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: table_address[13:0], table_value[30:14], tau_value[62:31], xi[79:63]
    input  logic [brts_pkg::S_TDATA_W-1:0]       s_tdata,
    // tuser: op[0]
    input  logic                                 s_tuser,
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: radius[16:0], zero fill above
    output logic [brts_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int RW  = $clog2(TAU_ROWS);
    localparam int CW  = $clog2(XI_COLS);
    localparam int AW  = brts_pkg::ADDR_W;
    localparam int EW  = brts_pkg::ENTRY_W;
    localparam int CPW = 17 + CW;
    localparam int RPW = 16 + RW;
    localparam logic [39:0]    RMAX     = 40'(TAU_ROWS - 1) << 16;
    localparam logic [RW-1:0]  ROW_LAST = RW'(TAU_ROWS - 2);
    localparam logic [CW:0]    COL_LAST = (CW + 1)'(XI_COLS - 2);

    // Configuration registers
    logic signed [brts_pkg::MIN_W-1:0] log2_min_reg;
    logic [brts_pkg::SCALE_W-1:0]      scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log2_min_reg <= '0;
            scale_reg    <= 32'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                brts_pkg::REG_LOG2_TAU_MIN:   log2_min_reg <= cfg_wr_data[23:0];
                brts_pkg::REG_POSITION_SCALE: scale_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the skid register is free
    logic skid_valid_reg;
    logic adv;
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // Input field unpacking
    logic [AW-1:0] in_addr;
    logic [EW-1:0] in_value;
    logic [31:0]   in_tau;
    logic [16:0]   in_xi;
    assign in_addr  = s_tdata[13:0];
    assign in_value = s_tdata[30:14];
    assign in_tau   = s_tdata[62:31];
    assign in_xi    = s_tdata[79:63];

    // Leading-one search and Mitchell mantissa for log2(tau)
    logic [4:0]         lead_pos;
    logic [31:0]        tau_norm;
    logic signed [21:0] log2_in;
    logic [16:0]        xi_clamped;
    logic [CPW-1:0]     cpos_in;

    always_comb begin
        lead_pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (in_tau[i]) begin
                lead_pos = 5'(i);
            end
        end
        tau_norm   = in_tau << (5'd31 - lead_pos);
        log2_in    = {6'({1'b0, lead_pos} - 6'd24), tau_norm[30:15]};
        xi_clamped = (in_xi > brts_pkg::ONE_Q16) ? brts_pkg::ONE_Q16 : in_xi;
        cpos_in    = CPW'(xi_clamped) * CPW'(XI_COLS - 1);
    end

    // Stage A: log2 and column position
    logic               va_reg;
    logic               opa_reg;
    logic [AW-1:0]      addra_reg;
    logic [EW-1:0]      vala_reg;
    logic               zeroa_reg;
    logic signed [21:0] loga_reg;
    logic [CPW-1:0]     cposa_reg;

    // Stage B: offset from the table minimum, column split
    logic               vb_reg;
    logic               opb_reg;
    logic [AW-1:0]      addrb_reg;
    logic [EW-1:0]      valb_reg;
    logic               posb_reg;
    logic [23:0]        diffb_reg;
    logic [CW-1:0]      colb_reg;
    logic [16:0]        cfracb_reg;

    // Stage C: scaled row position
    logic               vc_reg;
    logic               opc_reg;
    logic [AW-1:0]      addrc_reg;
    logic [EW-1:0]      valc_reg;
    logic [55:0]        prodc_reg;
    logic [CW-1:0]      colc_reg;
    logic [16:0]        cfracc_reg;

    // Stage D: clamped row position
    logic               vd_reg;
    logic               opd_reg;
    logic [AW-1:0]      addrd_reg;
    logic [EW-1:0]      vald_reg;
    logic [RPW-1:0]     rposd_reg;
    logic [CW-1:0]      cold_reg;
    logic [16:0]        cfracd_reg;

    // Stage E: table read data
    logic               ve_reg;
    logic [16:0]        rfrace_reg;
    logic [16:0]        cfrace_reg;

    // Stage F: column products
    logic               vf_reg;
    logic [EW-1:0]      a0f_reg;
    logic [EW-1:0]      a1f_reg;
    logic signed [35:0] p0f_reg;
    logic signed [35:0] p1f_reg;
    logic [16:0]        rfracf_reg;

    // Stage G: row endpoints
    logic               vg_reg;
    logic signed [19:0] r0g_reg;
    logic signed [19:0] r1g_reg;
    logic [16:0]        rfracg_reg;

    // Stage H: row product
    logic               vh_reg;
    logic signed [19:0] r0h_reg;
    logic signed [38:0] ph_reg;

    // Stage I: clamped result
    logic               vi_reg;
    logic [16:0]        resi_reg;

    // Stage B combinational terms
    logic signed [24:0] diff_a;
    logic [CW:0]        col_raw;
    logic [CW-1:0]      col_a;
    always_comb begin
        diff_a  = 25'(loga_reg) - 25'(log2_min_reg);
        col_raw = (CW + 1)'(cposa_reg >> 16);
        col_a   = (col_raw > COL_LAST) ? CW'(COL_LAST) : CW'(col_raw);
    end

    // Stage D combinational clamp
    logic [39:0] rpos_raw;
    assign rpos_raw = prodc_reg[55:16];

    // Stage E: row split and the four neighbor addresses
    logic [RW-1:0] row_d;
    logic [16:0]   rfrac_d;
    logic [31:0]   base_d;
    logic [AW-1:0] idx [4];
    logic [EW-1:0] ent [4];
    logic          sample_d;
    logic          write_d;

    always_comb begin
        row_d    = (rposd_reg[RPW-1:16] > ROW_LAST) ? ROW_LAST : rposd_reg[RPW-1:16];
        rfrac_d  = 17'(rposd_reg - (RPW'(row_d) << 16));
        base_d   = 32'(row_d) * 32'(XI_COLS) + 32'(cold_reg);
        idx[0]   = base_d[AW-1:0];
        idx[1]   = 14'(base_d + 32'd1);
        idx[2]   = 14'(base_d + 32'(XI_COLS));
        idx[3]   = 14'(base_d + 32'(XI_COLS) + 32'd1);
        sample_d = vd_reg && (opd_reg == brts_pkg::OP_SAMPLE);
        write_d  = adv && vd_reg && (opd_reg == brts_pkg::OP_WRITE);
    end

    // Four copies of the table, one per neighbor
    for (genvar k = 0; k < 4; k++) begin : g_bank
        brts_ram #(
            .WIDTH(EW),
            .DEPTH(brts_pkg::TDEPTH)
        ) u_ram (
            .aclk   (aclk),
            .wr_en  (write_d),
            .wr_addr(addrd_reg),
            .wr_data(vald_reg),
            .rd_en  (adv),
            .rd_addr(idx[k]),
            .rd_data(ent[k])
        );
    end

    // Stage F combinational differences
    logic signed [17:0] d0_e;
    logic signed [17:0] d1_e;
    logic signed [17:0] cf_e;
    always_comb begin
        d0_e = $signed({1'b0, ent[1]}) - $signed({1'b0, ent[0]});
        d1_e = $signed({1'b0, ent[3]}) - $signed({1'b0, ent[2]});
        cf_e = $signed({1'b0, cfrace_reg});
    end

    // Stage H combinational difference
    logic signed [20:0] dr_g;
    logic signed [17:0] rf_g;
    always_comb begin
        dr_g = 21'(r1g_reg) - 21'(r0g_reg);
        rf_g = $signed({1'b0, rfracg_reg});
    end

    // Stage I combinational sum and clamp
    logic signed [22:0] res_h;
    logic [16:0]        res_clamped;
    always_comb begin
        res_h = 23'(r0h_reg) + $signed(ph_reg[38:16]);
        if (res_h < 0) begin
            res_clamped = '0;
        end else if (res_h > 23'sd65536) begin
            res_clamped = brts_pkg::ONE_Q16;
        end else begin
            res_clamped = res_h[16:0];
        end
    end

    // Valid bits of the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= sample_d;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
            vh_reg <= vg_reg;
            vi_reg <= vh_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            opa_reg    <= s_tuser;
            addra_reg  <= in_addr;
            vala_reg   <= in_value;
            zeroa_reg  <= (in_tau == '0);
            loga_reg   <= log2_in;
            cposa_reg  <= cpos_in;

            opb_reg    <= opa_reg;
            addrb_reg  <= addra_reg;
            valb_reg   <= vala_reg;
            posb_reg   <= !zeroa_reg && !diff_a[24] && (diff_a != '0);
            diffb_reg  <= diff_a[23:0];
            colb_reg   <= col_a;
            cfracb_reg <= 17'(cposa_reg - (CPW'(col_a) << 16));

            opc_reg    <= opb_reg;
            addrc_reg  <= addrb_reg;
            valc_reg   <= valb_reg;
            prodc_reg  <= posb_reg ? (56'(diffb_reg) * 56'(scale_reg)) : '0;
            colc_reg   <= colb_reg;
            cfracc_reg <= cfracb_reg;

            opd_reg    <= opc_reg;
            addrd_reg  <= addrc_reg;
            vald_reg   <= valc_reg;
            rposd_reg  <= (rpos_raw > RMAX) ? RPW'(RMAX) : RPW'(rpos_raw);
            cold_reg   <= colc_reg;
            cfracd_reg <= cfracc_reg;

            rfrace_reg <= rfrac_d;
            cfrace_reg <= cfracd_reg;

            a0f_reg    <= ent[0];
            a1f_reg    <= ent[2];
            p0f_reg    <= 36'(cf_e) * 36'(d0_e);
            p1f_reg    <= 36'(cf_e) * 36'(d1_e);
            rfracf_reg <= rfrace_reg;

            r0g_reg    <= $signed({3'b0, a0f_reg}) + $signed(p0f_reg[35:16]);
            r1g_reg    <= $signed({3'b0, a1f_reg}) + $signed(p1f_reg[35:16]);
            rfracg_reg <= rfracf_reg;

            r0h_reg    <= r0g_reg;
            ph_reg     <= 39'(rf_g) * 39'(dr_g);

            resi_reg   <= res_clamped;
        end
    end

    // Output register with a skid stage behind it
    logic        m_valid_reg;
    logic [16:0] m_data_reg;
    logic [16:0] skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (m_valid_reg && !m_tready) begin
            skid_valid_reg <= vi_reg;
        end else begin
            m_valid_reg <= vi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (m_valid_reg && !m_tready) begin
            skid_data_reg <= resi_reg;
        end else begin
            m_data_reg <= resi_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

endmodule

@@ rtl/core/brts_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module brts_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int  TAU_ROWS   = 128;
    localparam int  XI_COLS    = 128;
    localparam int  DRAIN_WAIT = 16;
    localparam longint CYCLE_LIMIT = 600000;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [brts_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [brts_pkg::CFG_W-1:0]     cfg_wr_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [brts_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [brts_pkg::M_TDATA_W-1:0] m_tdata;

    // Predictor state: mirror of the table and both registers.
    logic [brts_pkg::ENTRY_W-1:0]   radius_mirror [brts_pkg::TDEPTH];
    bit                             entry_written [brts_pkg::TDEPTH];
    longint                         tau_min_q16;
    longint unsigned                rows_per_log2;

    logic [brts_pkg::ENTRY_W-1:0]   pending_radii[$];
    int                             send_idle_pct;
    int                             recv_idle_pct;
    int                             error_count;
    int                             samples_sent;
    int                             writes_sent;
    int                             items_sent;
    int                             radii_checked;
    longint                         cycle_count;

    bilinear_radius_table_sampler_unit #(
        .TAU_ROWS(TAU_ROWS),
        .XI_COLS (XI_COLS)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Interpolate between two entries, flooring the fractional step.
    function automatic longint blend_q16(longint a, longint b, longint f);
        return a + ((f * (b - a)) >>> 16);
    endfunction

    function automatic longint entry_at(longint unsigned row, longint unsigned col);
        return longint'(radius_mirror[(row * XI_COLS + col) & (brts_pkg::TDEPTH - 1)]);
    endfunction

    // Row and column of the upper-left neighbor, with both fractions.
    function automatic void locate_sample(input logic [31:0] tau, input logic [16:0] xi,
                                          output longint unsigned row,
                                          output longint unsigned col,
                                          output longint rfrac, output longint cfrac);
        int              p;
        longint unsigned rest, frac, rpos, cpos, xc;
        longint          log2_q16, diff;
        rpos = 0;
        if (tau != 0) begin
            p = 31;
            while (tau[p] == 1'b0) p--;
            rest = longint'(tau) & ~(64'd1 << p);
            frac = (p >= 16) ? (rest >> (p - 16)) : (rest << (16 - p));
            log2_q16 = longint'(p - 24) * 65536 + longint'(frac);
            diff = log2_q16 - tau_min_q16;
            if (diff > 0) begin
                rpos = (longint'(diff) * rows_per_log2) >> 16;
                if (rpos > (longint'(TAU_ROWS - 1) << 16)) rpos = longint'(TAU_ROWS - 1) << 16;
            end
        end
        row = rpos >> 16;
        if (row > TAU_ROWS - 2) row = TAU_ROWS - 2;
        rfrac = longint'(rpos - (row << 16));
        xc = (xi > brts_pkg::ONE_Q16) ? 65536 : xi;
        cpos = xc * (XI_COLS - 1);
        col = cpos >> 16;
        if (col > XI_COLS - 2) col = XI_COLS - 2;
        cfrac = longint'(cpos - (col << 16));
    endfunction

    // Expected radius for one sample transfer.
    function automatic logic [brts_pkg::ENTRY_W-1:0] predict_radius(logic [31:0] tau,
                                                                    logic [16:0] xi);
        longint unsigned row, col;
        longint          rfrac, cfrac, r0, r1, res;
        locate_sample(tau, xi, row, col, rfrac, cfrac);
        r0 = blend_q16(entry_at(row, col), entry_at(row, col + 1), cfrac);
        r1 = blend_q16(entry_at(row + 1, col), entry_at(row + 1, col + 1), cfrac);
        res = blend_q16(r0, r1, rfrac);
        if (res < 0) res = 0;
        if (res > 65536) res = 65536;
        return brts_pkg::ENTRY_W'(res);
    endfunction

    // Register write, only issued while the block is idle.
    task automatic write_register(logic [brts_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == brts_pkg::REG_LOG2_TAU_MIN) begin
            tau_min_q16 = longint'(signed'(value[23:0]));
        end else begin
            rows_per_log2 = value;
        end
        @(posedge aclk);
    endtask

    // Send one transfer with an optional leading gap; predict on acceptance.
    task automatic send_item(logic op, logic [13:0] addr, logic [16:0] value,
                             logic [31:0] tau, logic [16:0] xi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {xi, tau, value, addr};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (op == brts_pkg::OP_WRITE) begin
            radius_mirror[addr] = value;
            entry_written[addr] = 1'b1;
            writes_sent++;
        end else begin
            pending_radii.push_back(predict_radius(tau, xi));
            samples_sent++;
        end
    endtask

    function automatic logic [16:0] random_entry();
        return ($urandom_range(9) == 0) ? 17'($urandom_range(131071))
                                        : 17'($urandom_range(65536));
    endfunction

    // A sample first writes any of its four neighbors that are still unwritten.
    task automatic send_sample(logic [31:0] tau, logic [16:0] xi);
        longint unsigned row, col;
        longint          rfrac, cfrac;
        logic [13:0]     nidx [4];
        locate_sample(tau, xi, row, col, rfrac, cfrac);
        nidx[0] = 14'(row * XI_COLS + col);
        nidx[1] = 14'(row * XI_COLS + col + 1);
        nidx[2] = 14'((row + 1) * XI_COLS + col);
        nidx[3] = 14'((row + 1) * XI_COLS + col + 1);
        for (int k = 0; k < 4; k++) begin
            if (!entry_written[nidx[k]]) begin
                send_item(brts_pkg::OP_WRITE, nidx[k], random_entry(), '0, '0);
            end
        end
        send_item(brts_pkg::OP_SAMPLE, '0, '0, tau, xi);
    endtask

    // Wait for every expected result, then let the pipeline drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_radii.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_tau();
        return $urandom >> $urandom_range(31);
    endfunction

    function automatic logic [16:0] random_xi();
        case ($urandom_range(7))
            0:       return 17'($urandom_range(131071));
            1:       return brts_pkg::ONE_Q16;
            default: return 17'($urandom_range(65535));
        endcase
    endfunction

    // Field extremes and the named corner cases under reset settings.
    task automatic test_directed();
        send_item(brts_pkg::OP_WRITE, 14'd0, 17'd131071, '0, '0);
        send_item(brts_pkg::OP_WRITE, 14'd16383, brts_pkg::ONE_Q16, '0, '0);
        send_item(brts_pkg::OP_WRITE, 14'd129, 17'd0, '0, '0);
        send_sample(32'd0, 17'd0);
        send_sample(32'd0, brts_pkg::ONE_Q16);
        send_sample(32'd1, 17'd1);
        send_sample(32'hFFFF_FFFF, 17'd131071);
        send_sample(32'hFFFF_FFFF, 17'd65535);
        send_sample(32'h0100_0000, 17'd32768);
        send_sample(32'h00FF_FFFF, 17'd516);
        send_sample(32'h8000_0000, 17'h1_5555);
        send_sample(32'h0001_8000, 17'h0AAAA);
        send_sample(32'h5555_5555, 17'd0);
        send_sample(32'hAAAA_AAAA, brts_pkg::ONE_Q16);
        wait_idle();
    endtask

    // Register extremes, a few samples under each.
    task automatic test_register_sweep();
        logic [31:0] mins[4]   = '{32'h0080_0000, 32'h007F_FFFF, 32'h00FF_0000, 32'h0};
        logic [31:0] scales[4] = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0008_0000};
        for (int i = 0; i < 4; i++) begin
            write_register(brts_pkg::REG_LOG2_TAU_MIN, mins[i]);
            write_register(brts_pkg::REG_POSITION_SCALE, scales[i]);
            repeat (6) send_sample(random_tau(), random_xi());
            wait_idle();
        end
    endtask

    // Mixed stream of writes and samples under one idling pattern.
    task automatic test_random_phase(int send_pct, int recv_pct, int count);
        int first_item;
        bit held;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_register(brts_pkg::REG_LOG2_TAU_MIN,
                       32'($urandom_range(16777215)) & 32'h00FF_FFFF);
        write_register(brts_pkg::REG_POSITION_SCALE, $urandom >> $urandom_range(20));
        first_item = items_sent;
        held       = 1'b0;
        while (items_sent - first_item < count) begin
            if ($urandom_range(9) < 3) begin
                send_item(brts_pkg::OP_WRITE, 14'($urandom), random_entry(), '0, '0);
            end else begin
                send_sample(random_tau(), random_xi());
            end
            // Hold the sender once until the pipeline has emptied.
            if (!held && (items_sent - first_item >= count / 2)) begin
                wait_idle();
                held = 1'b1;
            end
        end
        wait_idle();
    endtask

    // Receiver readiness.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checking against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_radii.size() == 0) begin
                $display("%0t: unexpected radius transfer, actual %0d", $time, m_tdata);
                error_count++;
            end else begin
                if (m_tdata !== {{(brts_pkg::M_TDATA_W - brts_pkg::ENTRY_W){1'b0}},
                                 pending_radii[0]}) begin
                    $display("%0t: radius mismatch, expected %0d, actual %0d",
                             $time, pending_radii[0], m_tdata);
                    error_count++;
                end
                void'(pending_radii.pop_front());
                radii_checked++;
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bilinear_radius_table_sampler_unit test failed");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        tau_min_q16   = 0;
        rows_per_log2 = 65536;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        error_count   = 0;
        samples_sent  = 0;
        writes_sent   = 0;
        items_sent    = 0;
        radii_checked = 0;
        cycle_count   = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_register_sweep();
        test_random_phase(8, 53, 200);
        test_random_phase(53, 8, 200);
        test_random_phase(0, 0, 200);

        $display("Sent %0d table writes and %0d samples; entries were written just before",
                 writes_sent, samples_sent);
        $display("the first sample needing them. Checked %0d radii over corner fields, %s",
                 radii_checked, "register extremes and three stall patterns.");
        if (error_count == 0 && pending_radii.size() == 0) begin
            $display("bilinear_radius_table_sampler_unit test passed");
        end else begin
            $display("bilinear_radius_table_sampler_unit test failed");
        end
        $finish;
    end

endmodule
